// ===== hdl/bdl_pkg.sv =====
// Shared types and constants of the base-delta line compressor.
package bdl_pkg;

    localparam int WORD_W    = 64;
    localparam int NUM_WORDS = 8;
    localparam int LINE_W    = WORD_W * NUM_WORDS;
    localparam int REC_W     = 7;
    localparam int TOTAL_W   = 23;
    localparam int LINES_W   = 17;
    localparam int TYPE_W    = 2;
    localparam int OUT_DATA_W = 184;

    localparam logic [TOTAL_W-1:0] HEADER_BYTES   = 23'd4;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX      = 23'd8388607;
    localparam logic [TOTAL_W-1:0] CAPACITY_RESET = 23'd4259844;

    localparam logic [REC_W-1:0] REC_ZERO   = 7'd1;
    localparam logic [REC_W-1:0] REC_REPEAT = 7'd9;
    localparam logic [REC_W-1:0] REC_DELTA  = 7'd17;
    localparam logic [REC_W-1:0] REC_RAW    = 7'd65;

    typedef enum logic [TYPE_W-1:0] {
        LT_RAW    = 2'd0,
        LT_ZERO   = 2'd1,
        LT_REPEAT = 2'd2,
        LT_DELTA  = 2'd3
    } t_line_type;

    typedef struct packed {
        t_line_type          line_type;
        logic [WORD_W-1:0]   base_word;
        logic [WORD_W-1:0]   packed_deltas;
        logic [REC_W-1:0]    record_bytes;
    } t_class;

    typedef struct packed {
        logic [TOTAL_W-1:0] total_bytes;
        logic [LINES_W-1:0] lines_seen;
        logic               capacity_exceeded;
        logic               not_smaller;
    } t_acct;

endpackage

// ===== hdl/bdl_classify.sv =====
// Line classifier: zero, repeated base, byte deltas or uncompressed.
module bdl_classify (
    input  logic [bdl_pkg::LINE_W-1:0] i_line,
    output bdl_pkg::t_class             o_class
);

    logic [bdl_pkg::WORD_W-1:0] w_base;
    logic [bdl_pkg::WORD_W-1:0] w_diff [bdl_pkg::NUM_WORDS];
    logic [bdl_pkg::NUM_WORDS-1:0] w_zero;
    logic [bdl_pkg::NUM_WORDS-1:0] w_same;
    logic [bdl_pkg::NUM_WORDS-1:0] w_fits;
    logic [bdl_pkg::WORD_W-1:0] w_packed;

    assign w_base = i_line[bdl_pkg::WORD_W-1:0];

    always_comb begin
        for (int k = 0; k < bdl_pkg::NUM_WORDS; k++) begin
            w_diff[k]   = i_line[k*bdl_pkg::WORD_W +: bdl_pkg::WORD_W] - w_base;
            w_zero[k]   = (i_line[k*bdl_pkg::WORD_W +: bdl_pkg::WORD_W] == '0);
            w_same[k]   = (w_diff[k] == '0);
            // A signed byte holds the difference when bits 63 down to 7 agree.
            w_fits[k]   = (&w_diff[k][bdl_pkg::WORD_W-1:7]) | ~(|w_diff[k][bdl_pkg::WORD_W-1:7]);
            w_packed[k*8 +: 8] = w_diff[k][7:0];
        end
    end

    always_comb begin
        o_class.base_word     = '0;
        o_class.packed_deltas = '0;
        if (&w_zero) begin
            o_class.line_type    = bdl_pkg::LT_ZERO;
            o_class.record_bytes = bdl_pkg::REC_ZERO;
        end else if (&w_same) begin
            o_class.line_type    = bdl_pkg::LT_REPEAT;
            o_class.record_bytes = bdl_pkg::REC_REPEAT;
            o_class.base_word    = w_base;
        end else if (&w_fits) begin
            o_class.line_type     = bdl_pkg::LT_DELTA;
            o_class.record_bytes  = bdl_pkg::REC_DELTA;
            o_class.base_word     = w_base;
            o_class.packed_deltas = w_packed;
        end else begin
            o_class.line_type    = bdl_pkg::LT_RAW;
            o_class.record_bytes = bdl_pkg::REC_RAW;
        end
    end

endmodule

// ===== hdl/bdl_account.sv =====
// Stream accounting: running size, line count, capacity flag, not-smaller flag and capacity register.
module bdl_account #(
    parameter int MAX_LINES = 65536,
    parameter int CNT_W     = 17
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [bdl_pkg::TOTAL_W-1:0]   i_cfg_wr_data,
    input  logic                          i_step,
    input  logic [bdl_pkg::REC_W-1:0]     i_rec,
    input  logic                          i_last,
    output bdl_pkg::t_acct                o_acct
);

    localparam int CMP_W = CNT_W + bdl_pkg::TOTAL_W;

    logic [bdl_pkg::TOTAL_W-1:0] r_cap;
    logic [bdl_pkg::TOTAL_W-1:0] r_total, n_total;
    logic [CNT_W-1:0]            r_count, n_count;
    logic                        r_flag, n_flag;

    logic [bdl_pkg::TOTAL_W:0]   w_sum;
    logic [CMP_W-1:0]            w_total_ext;
    logic [CMP_W-1:0]            w_count_x64;
    logic [CNT_W+bdl_pkg::LINES_W-1:0] w_count_ext;

    always_comb begin
        w_sum   = {1'b0, r_total} + (bdl_pkg::TOTAL_W+1)'(i_rec);
        n_total = w_sum[bdl_pkg::TOTAL_W] ? bdl_pkg::TOTAL_MAX : w_sum[bdl_pkg::TOTAL_W-1:0];
        n_count = (r_count < CNT_W'(MAX_LINES)) ? r_count + 1'b1 : r_count;
        n_flag  = r_flag | (n_total > r_cap);

        w_total_ext = CMP_W'(n_total);
        w_count_x64 = CMP_W'({n_count, 6'b0});
        w_count_ext = (CNT_W+bdl_pkg::LINES_W)'(n_count);

        o_acct.total_bytes       = n_total;
        o_acct.lines_seen        = w_count_ext[bdl_pkg::LINES_W-1:0];
        o_acct.capacity_exceeded = n_flag;
        o_acct.not_smaller       = i_last & (w_total_ext >= w_count_x64);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= bdl_pkg::CAPACITY_RESET;
        end else if (i_cfg_wr_en) begin
            r_cap <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= bdl_pkg::HEADER_BYTES;
            r_count <= '0;
            r_flag  <= 1'b0;
        end else if (i_step) begin
            if (i_last) begin
                r_total <= bdl_pkg::HEADER_BYTES;
                r_count <= '0;
                r_flag  <= 1'b0;
            end else begin
                r_total <= n_total;
                r_count <= n_count;
                r_flag  <= n_flag;
            end
        end
    end

endmodule

// ===== hdl/base_delta_line_compressor_top.sv =====
// A line accepted at the input is held in the input register, then moves to the output register, which presents it.
// Throughput: one line per cycle while the output is ready; the input register can still fill while the output stalls.
// The stream accounting updates once per line as it moves to the output register.
// Reset is synchronous and active low; it empties both registers, restarts the
// running size at the 4-byte header and returns the capacity to its default.
module base_delta_line_compressor_top #(
    parameter int MAX_LINES = 65536
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [bdl_pkg::TOTAL_W-1:0]       i_cfg_wr_data,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // Fields from bit 0: word_0 to word_7, 64 bits each.
    input  logic [bdl_pkg::LINE_W-1:0]        i_s_axis_tdata,
    input  logic                              i_s_axis_tlast,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // Fields from bit 0: base_word, packed_deltas, record_bytes, total_bytes,
    // lines_seen, capacity_exceeded, not_smaller, zero fill.
    output logic [bdl_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    // Field: line_type.
    output logic [bdl_pkg::TYPE_W-1:0]        o_m_axis_tuser,
    output logic                              o_m_axis_tlast
);

    localparam int CNT_W = $clog2(MAX_LINES + 1);
    localparam int PAY_W = 2 * bdl_pkg::WORD_W + bdl_pkg::REC_W + bdl_pkg::TOTAL_W
                         + bdl_pkg::LINES_W + 2;

    logic                          r_in_valid;
    logic [bdl_pkg::LINE_W-1:0]    r_in_line;
    logic                          r_in_last;

    logic                          r_out_valid;
    bdl_pkg::t_class               r_out_class;
    bdl_pkg::t_acct                r_out_acct;
    logic                          r_out_last;

    logic                          w_adv;
    logic                          w_step;
    bdl_pkg::t_class               w_class;
    bdl_pkg::t_acct                w_acct;
    logic [PAY_W-1:0]              w_payload;

    assign w_adv           = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || w_adv;
    assign w_step          = r_in_valid && w_adv;

    bdl_classify u_classify (
        .i_line  (r_in_line),
        .o_class (w_class)
    );

    bdl_account #(
        .MAX_LINES (MAX_LINES),
        .CNT_W     (CNT_W)
    ) u_account (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_step        (w_step),
        .i_rec         (w_class.record_bytes),
        .i_last        (r_in_last),
        .o_acct        (w_acct)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_line <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_class <= w_class;
            r_out_acct  <= w_acct;
            r_out_last  <= r_in_last;
        end
    end

    assign w_payload = {r_out_acct.not_smaller,
                        r_out_acct.capacity_exceeded,
                        r_out_acct.lines_seen,
                        r_out_acct.total_bytes,
                        r_out_class.record_bytes,
                        r_out_class.packed_deltas,
                        r_out_class.base_word};

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = bdl_pkg::OUT_DATA_W'(w_payload);
    assign o_m_axis_tuser  = r_out_class.line_type;
    assign o_m_axis_tlast  = r_out_last;

endmodule

// ===== test/base_delta_line_compressor_top_tb.sv =====
// Self-checking testbench for the base-delta line compressor with randomized stream traffic.
`timescale 1ns / 1ps

module base_delta_line_compressor_top_tb;

    localparam int WORD_W     = bdl_pkg::WORD_W;
    localparam int NUM_WORDS  = bdl_pkg::NUM_WORDS;
    localparam int LINE_W     = bdl_pkg::LINE_W;
    localparam int REC_W      = bdl_pkg::REC_W;
    localparam int TOTAL_W    = bdl_pkg::TOTAL_W;
    localparam int LINES_W    = bdl_pkg::LINES_W;
    localparam int TYPE_W     = bdl_pkg::TYPE_W;
    localparam int OUT_DATA_W = bdl_pkg::OUT_DATA_W;

    localparam int LINE_LIMIT = 65536;
    localparam int REC_LSB    = 2 * WORD_W;
    localparam int TOTAL_LSB  = REC_LSB + REC_W;
    localparam int LINES_LSB  = TOTAL_LSB + TOTAL_W;
    localparam int OVER_BIT   = LINES_LSB + LINES_W;
    localparam int NSM_BIT    = OVER_BIT + 1;

    typedef struct {
        bdl_pkg::t_line_type ltype;
        logic [WORD_W-1:0]   base;
        logic [WORD_W-1:0]   deltas;
        logic [REC_W-1:0]    rec_bytes;
        logic [TOTAL_W-1:0]  total;
        logic [LINES_W-1:0]  lines;
        logic                over;
        logic                nsm;
        logic                eos;
    } t_line_record;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [TOTAL_W-1:0]     cfg_wr_data = '0;
    logic                   s_valid = 1'b0;
    logic [LINE_W-1:0]      s_data = '0;
    logic                   s_last = 1'b0;
    logic                   m_ready = 1'b0;
    logic                   s_ready;
    logic                   m_valid;
    logic [OUT_DATA_W-1:0]  m_data;
    logic [TYPE_W-1:0]      m_user;
    logic                   m_last;

    t_line_record           expected_lines[$];
    longint unsigned        stream_total = 64'(bdl_pkg::HEADER_BYTES);
    int unsigned            stream_lines = 0;
    logic                   stream_over = 1'b0;
    int unsigned            capacity = 32'(bdl_pkg::CAPACITY_RESET);
    int                     error_count = 0;
    int                     send_idle_pct = 20;
    int                     recv_idle_pct = 30;
    int                     hold_req = 0;

    base_delta_line_compressor_top #(
        .MAX_LINES(LINE_LIMIT)
    ) u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata (s_data),
        .i_s_axis_tlast (s_last),
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (m_data),
        .o_m_axis_tuser (m_user),
        .o_m_axis_tlast (m_last)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic predict_line_record(input logic [LINE_W-1:0] line, input logic last);
        logic [WORD_W-1:0] base;
        logic [WORD_W-1:0] w;
        logic [WORD_W-1:0] d;
        logic [WORD_W-1:0] packed_d;
        logic              zero_line;
        logic              same_line;
        logic              all_fit;
        t_line_record      r;
        base = line[WORD_W-1:0];
        zero_line = 1'b1;
        same_line = 1'b1;
        all_fit = 1'b1;
        packed_d = '0;
        for (int i = 0; i < NUM_WORDS; i++) begin
            w = line[i*WORD_W +: WORD_W];
            d = w - base;
            if (w != '0) zero_line = 1'b0;
            if (w != base) same_line = 1'b0;
            if ($signed(d) < -128 || $signed(d) > 127) all_fit = 1'b0;
            packed_d[8*i +: 8] = d[7:0];
        end
        r.base = '0;
        r.deltas = '0;
        if (zero_line) begin
            r.ltype = bdl_pkg::LT_ZERO;
            r.rec_bytes = bdl_pkg::REC_ZERO;
        end else if (same_line) begin
            r.ltype = bdl_pkg::LT_REPEAT;
            r.rec_bytes = bdl_pkg::REC_REPEAT;
            r.base = base;
        end else if (all_fit) begin
            r.ltype = bdl_pkg::LT_DELTA;
            r.rec_bytes = bdl_pkg::REC_DELTA;
            r.base = base;
            r.deltas = packed_d;
        end else begin
            r.ltype = bdl_pkg::LT_RAW;
            r.rec_bytes = bdl_pkg::REC_RAW;
        end
        stream_total = stream_total + 64'(r.rec_bytes);
        if (stream_total > bdl_pkg::TOTAL_MAX) stream_total = 64'(bdl_pkg::TOTAL_MAX);
        if (stream_lines < LINE_LIMIT) stream_lines++;
        if (stream_total > capacity) stream_over = 1'b1;
        r.total = stream_total[TOTAL_W-1:0];
        r.lines = stream_lines[LINES_W-1:0];
        r.over = stream_over;
        r.nsm = last && (stream_total >= 64 * longint'(stream_lines));
        r.eos = last;
        expected_lines.push_back(r);
        if (last) begin
            stream_total = 64'(bdl_pkg::HEADER_BYTES);
            stream_lines = 0;
            stream_over = 1'b0;
        end
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] expv,
                               input logic [WORD_W-1:0] actv);
        if (expv !== actv) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, expv, actv);
            error_count++;
        end
    endtask

    task automatic check_line_record();
        t_line_record r;
        if (expected_lines.size() == 0) begin
            $display("%0t: unexpected transfer, expected none, actual tdata %h tuser %h",
                     $time, m_data, m_user);
            error_count++;
        end else begin
            r = expected_lines.pop_front();
            check_field("line_type", WORD_W'(r.ltype), WORD_W'(m_user));
            check_field("base_word", r.base, m_data[WORD_W-1:0]);
            check_field("packed_deltas", r.deltas, m_data[WORD_W +: WORD_W]);
            check_field("record_bytes", WORD_W'(r.rec_bytes),
                        WORD_W'(m_data[REC_LSB +: REC_W]));
            check_field("total_bytes", WORD_W'(r.total),
                        WORD_W'(m_data[TOTAL_LSB +: TOTAL_W]));
            check_field("lines_seen", WORD_W'(r.lines),
                        WORD_W'(m_data[LINES_LSB +: LINES_W]));
            check_field("capacity_exceeded", WORD_W'(r.over), WORD_W'(m_data[OVER_BIT]));
            check_field("not_smaller", WORD_W'(r.nsm), WORD_W'(m_data[NSM_BIT]));
            check_field("end_of_stream", WORD_W'(r.eos), WORD_W'(m_last));
        end
    endtask

    // The receiver checks each output transfer and decides its ready for the next cycle.
    always @(posedge clk) begin
        int hold_left;
        if (rst_n && m_valid && m_ready) check_line_record();
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_line(input logic [LINE_W-1:0] line, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data <= line;
        s_last <= last;
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        predict_line_record(line, last);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge clk);
        while (expected_lines.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [TOTAL_W-1:0] value);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        capacity = 32'(value);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [WORD_W-1:0] rand_base();
        case ($urandom_range(11))
            0: return '0;
            1: return '1;
            2: return 64'h8000_0000_0000_0000;
            3: return 64'h7FFF_FFFF_FFFF_FFFF;
            4: return 64'h0000_0000_0000_007F;
            5: return 64'hFFFF_FFFF_FFFF_FF80;
            default: return rand_word();
        endcase
    endfunction

    // Word 0 is the base; bytes 1 to 7 of offs are sign-extended and added to it.
    function automatic logic [LINE_W-1:0] line_from_deltas(input logic [WORD_W-1:0] base,
                                                           input logic [WORD_W-1:0] offs);
        logic [LINE_W-1:0]        line;
        logic signed [WORD_W-1:0] off;
        line[WORD_W-1:0] = base;
        for (int i = 1; i < NUM_WORDS; i++) begin
            off = WORD_W'($signed(offs[8*i +: 8]));
            line[i*WORD_W +: WORD_W] = base + off;
        end
        return line;
    endfunction

    function automatic logic [LINE_W-1:0] random_line();
        logic [LINE_W-1:0]        line;
        logic [WORD_W-1:0]        base;
        logic signed [WORD_W-1:0] off;
        int                       v;
        base = rand_base();
        line = {NUM_WORDS{base}};
        case ($urandom_range(19)) inside
            [0:2]: line = '0;
            [3:5]: ;
            [6:12]:
                line = line_from_deltas(base, rand_word());
            [13:15]: begin
                for (int i = 1; i < NUM_WORDS; i++) begin
                    v = $urandom_range(280);
                    off = WORD_W'(v - 140);
                    line[i*WORD_W +: WORD_W] = base + off;
                end
            end
            16: line[$urandom_range(NUM_WORDS-1)*WORD_W +: WORD_W] = rand_word();
            default: begin
                for (int i = 0; i < NUM_WORDS; i++) line[i*WORD_W +: WORD_W] = rand_word();
            end
        endcase
        return line;
    endfunction

    function automatic logic [LINE_W-1:0] raw_line();
        logic [LINE_W-1:0] line;
        for (int i = 0; i < NUM_WORDS; i++) line[i*WORD_W +: WORD_W] = rand_word();
        line[WORD_W +: WORD_W] = line[WORD_W-1:0] + 64'h1000;
        return line;
    endfunction

    task automatic test_directed_lines();
        logic [LINE_W-1:0] line;
        send_line('0, 1'b0);
        send_line({NUM_WORDS{64'hFFFF_FFFF_FFFF_FFFF}}, 1'b0);
        send_line(line_from_deltas('0, 64'hC040_00FF_017F_8000), 1'b0);
        send_line(line_from_deltas('1, 64'h807F_0102_FEFF_7F00), 1'b0);
        send_line(line_from_deltas(64'h8000_0000_0000_0000, 64'h7F80_7F80_0000_0100), 1'b0);
        send_line(line_from_deltas(64'h7FFF_FFFF_FFFF_FFFF, 64'h807F_807F_0000_0100), 1'b0);
        line = {NUM_WORDS{64'h7FFF_FFFF_FFFF_FFFF}};
        line[WORD_W +: WORD_W] = 64'h8000_0000_0000_007F;
        send_line(line, 1'b0);
        line = {NUM_WORDS{64'd5}};
        line[3*WORD_W +: WORD_W] = 64'd5 - 64'd129;
        send_line(line, 1'b0);
        line = '0;
        line[7*WORD_W +: WORD_W] = 64'hDEAD_BEEF_0000_0000;
        send_line(line, 1'b0);
        line = '0;
        line[WORD_W-1:0] = 64'd100;
        send_line(line, 1'b0);
        line = {NUM_WORDS{64'd1}};
        line[WORD_W-1:0] = '0;
        send_line(line, 1'b0);
        send_line({NUM_WORDS{64'h5555_AAAA_5555_AAAA}}, 1'b0);
        send_line(raw_line(), 1'b1);
        send_line('0, 1'b1);
        send_line(raw_line(), 1'b1);
        send_line('0, 1'b0);
        send_line('0, 1'b0);
        send_line({NUM_WORDS{64'h0123_4567_89AB_CDEF}}, 1'b1);
    endtask

    task automatic test_capacity_settings();
        logic [TOTAL_W-1:0] caps[6];
        caps = '{23'd0, 23'd3, 23'd4, 23'd5, 23'd69, bdl_pkg::CAPACITY_RESET};
        foreach (caps[k]) begin
            write_capacity(caps[k]);
            send_line('0, 1'b0);
            send_line(raw_line(), 1'b0);
            send_line(raw_line(), 1'b1);
            send_line(raw_line(), 1'b0);
            send_line('0, 1'b1);
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        wait_drained();
        hold_req = 300;
        for (int n = 0; n < 24; n++) send_line(random_line(), $urandom_range(9) == 0);
        wait_drained();
    endtask

    task automatic test_random_lines();
        int send_pct[3];
        int recv_pct[3];
        send_pct = '{33, 76, 0};
        recv_pct = '{76, 33, 0};
        for (int p = 0; p < 3; p++) begin
            send_idle_pct = send_pct[p];
            recv_idle_pct = recv_pct[p];
            for (int c = 0; c < 4; c++) begin
                case ($urandom_range(3))
                    0: write_capacity(TOTAL_W'($urandom_range(6000)));
                    1: write_capacity(TOTAL_W'($urandom_range(400)));
                    2: write_capacity(bdl_pkg::CAPACITY_RESET);
                    default: write_capacity(TOTAL_W'($urandom_range(bdl_pkg::CAPACITY_RESET)));
                endcase
                for (int n = 0; n < 90; n++) send_line(random_line(), $urandom_range(39) == 0);
            end
        end
    endtask

    task automatic test_long_run();
        send_idle_pct = 0;
        recv_idle_pct = 5;
        write_capacity(23'd3000);
        for (int n = 0; n < 100; n++) send_line(raw_line(), 1'b0);
        send_line('0, 1'b1);
        send_line(raw_line(), 1'b1);
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_lines();
        test_capacity_settings();
        test_backpressure();
        test_random_lines();
        test_long_run();
        wait_drained();
        repeat (4) @(posedge clk);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
